>>> hw/rtl/obo_pkg.sv
// Package: payload types, constants and arctangent table for the odometry integrator.
`timescale 1ns / 1ps
package obo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 32;
    localparam int MAX_STEPS        = 24;

    localparam logic [23:0] COEF_A_RST = 24'd738100;
    localparam logic [23:0] COEF_B_RST = 24'd426141;
    localparam logic [24:0] COEF_C_RST = 25'h1E575B3; // -1739341

    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [23:0] wheel_speed_1;
        logic signed [23:0] wheel_speed_2;
        logic signed [23:0] wheel_speed_3;
        logic        [15:0] time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic        [31:0] heading;
        logic signed [31:0] world_vel_x;
        logic signed [31:0] world_vel_y;
        logic signed [31:0] turn_rate;
    } t_out_item;

    // Arctangent per CORDIC step, 2^32 per turn
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/omni_base_odometry_integrator_unit.sv
// Top level: three-wheel omni base odometry integrator.
// A result is computed through the states BODY, CORD, ROT, POS, HEAD and OUT in turn.
// One item at a time: o_stall is raised while busy, so no new item is taken until the block is idle again.
// The CORDIC iterations and one shared signed multiplier set the item time.
// Reset (synchronous, active low) clears pose, heading, output valid, and
// returns the coefficient registers to their defaults.
`timescale 1ns / 1ps
module omni_base_odometry_integrator_unit
    import obo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [24:0] i_cfg_data
);

    localparam int NSTEP = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
    localparam logic [31:0] ANG_MASK = 32'hFFFFFFFF << (32 - ANGLE_BITS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_BODY = 7'b0000010,
        S_CORD = 7'b0000100,
        S_ROT  = 7'b0001000,
        S_POS  = 7'b0010000,
        S_HEAD = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_sub;  // step inside a multiply phase
    logic [4:0] r_it;   // CORDIC iteration

    logic [23:0] r_coef_a, r_coef_b;
    logic signed [24:0] r_coef_c;
    logic signed [31:0] r_pos_x, r_pos_y;
    logic [31:0] r_head;

    t_in_item r_in;
    logic signed [31:0] r_vx, r_vy, r_wz;
    logic signed [33:0] r_cx, r_cy;
    logic signed [33:0] r_z;
    logic r_flip;
    logic signed [31:0] r_gx, r_gy;
    logic signed [65:0] r_acc;
    logic signed [65:0] r_prod;
    logic signed [47:0] r_p;
    logic [47:0] r_m;
    t_out_item r_out;
    logic r_ovalid;

    // Shared multiplier operands
    logic signed [33:0] w_ma;
    logic signed [33:0] w_mb;
    logic signed [67:0] w_mul;

    logic signed [25:0] w_d21, w_d3, w_sum;

    assign w_d21 = 26'(r_in.wheel_speed_2) - 26'(r_in.wheel_speed_1);
    assign w_d3  = 26'(r_in.wheel_speed_3) * 26'sd2 - 26'(r_in.wheel_speed_1)
                 - 26'(r_in.wheel_speed_2);
    assign w_sum = 26'(r_in.wheel_speed_1) + 26'(r_in.wheel_speed_2)
                 + 26'(r_in.wheel_speed_3);

    // Select operands for the one multiplier by phase and step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_BODY: begin
                case (r_sub)
                    4'd0: begin w_ma = 34'(signed'({1'b0, r_coef_a})); w_mb = 34'(w_d21); end
                    4'd1: begin w_ma = 34'(signed'({1'b0, r_coef_b})); w_mb = 34'(w_d3); end
                    default: begin w_ma = 34'(r_coef_c); w_mb = 34'(w_sum); end
                endcase
            end
            S_ROT: begin
                case (r_sub)
                    4'd0: begin w_ma = r_cx; w_mb = 34'(r_vx); end
                    4'd1: begin w_ma = r_cy; w_mb = 34'(r_vy); end
                    4'd2: begin w_ma = r_cy; w_mb = 34'(r_vx); end
                    default: begin w_ma = r_cx; w_mb = 34'(r_vy); end
                endcase
            end
            S_POS: begin
                w_ma = (r_sub == 4'd0) ? 34'(r_gx) : 34'(r_gy);
                w_mb = 34'(signed'({1'b0, r_in.time_step}));
            end
            S_HEAD: begin
                w_ma = 34'(r_wz);
                w_mb = 34'(signed'({1'b0, r_in.time_step}));
            end
            default: ;
        endcase
    end
    assign w_mul = w_ma * w_mb;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [65:0] rnd(input logic signed [65:0] v, input int s);
        return (v + (66'sd1 <<< (s - 1))) >>> s;
    endfunction

    // CORDIC shared step
    logic signed [33:0] w_sx, w_sy;
    logic signed [33:0] w_nx, w_ny;
    logic [31:0] w_atan;
    logic [31:0] w_zi;
    assign w_sx = r_cx >>> r_it;
    assign w_sy = r_cy >>> r_it;
    assign w_nx = r_z[33] ? r_cx + w_sy : r_cx - w_sy;
    assign w_ny = r_z[33] ? r_cy - w_sx : r_cy + w_sx;
    assign w_atan = atan_lut(r_it);
    assign w_zi = r_head & ANG_MASK;

    // Heading step constants
    logic [63:0] w_t, w_smag;
    assign w_t = 64'(r_m) * 64'd10430 + ((64'(r_m) * 64'd27100 + 64'd32768) >> 16);
    assign w_smag = (w_t + 64'd32768) >> 16;

    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && !o_stall) n_state = S_BODY;
            S_BODY: if (r_sub == 4'd3) n_state = S_CORD;
            S_CORD: if (32'(r_it) == NSTEP - 1) n_state = S_ROT;
            S_ROT:  if (r_sub == 4'd4) n_state = S_POS;
            S_POS:  if (r_sub == 4'd2) n_state = S_HEAD;
            S_HEAD: if (r_sub == 4'd2) n_state = S_OUT;
            S_OUT:  if (!r_ovalid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sub    <= '0;
            r_it     <= '0;
            r_ovalid <= 1'b0;
            r_coef_a <= COEF_A_RST;
            r_coef_b <= COEF_B_RST;
            r_coef_c <= COEF_C_RST;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_head   <= '0;
        end else begin
            r_state <= n_state;
            r_sub   <= (n_state != r_state) ? 4'd0 : r_sub + 4'd1;
            // Write configuration
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_COEF_A: r_coef_a <= i_cfg_data[23:0];
                    REG_COEF_B: r_coef_b <= i_cfg_data[23:0];
                    REG_COEF_C: r_coef_c <= i_cfg_data;
                    default: ;
                endcase
            end
            // Raise valid on a new result, drop it once taken
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_in <= i_data;
                        // Fold the angle into the right half plane
                        if (w_zi >= 32'h40000000 && w_zi < 32'hC0000000) begin
                            r_z <= 34'(signed'(w_zi - 32'h80000000));
                            r_flip <= 1'b1;
                        end else begin
                            r_z <= 34'(signed'(w_zi));
                            r_flip <= 1'b0;
                        end
                        r_cx <= CORDIC_GAIN;
                        r_cy <= '0;
                        r_it <= '0;
                    end
                end
                S_BODY: begin
                    r_prod <= 66'(w_mul);
                    case (r_sub)
                        4'd1: r_vx <= 32'(rnd(r_prod, 24));
                        4'd2: r_vy <= 32'(rnd(r_prod, 24));
                        4'd3: r_wz <= 32'(rnd(r_prod, 24));
                        default: ;
                    endcase
                end
                S_CORD: begin
                    if (!r_z[33]) begin
                        r_z <= r_z - 34'(w_atan);
                    end else begin
                        r_z <= r_z + 34'(w_atan);
                    end
                    r_it <= r_it + 5'd1;
                    // Negate on the last step when the angle was folded
                    if (32'(r_it) == NSTEP - 1 && r_flip) begin
                        r_cx <= -w_nx;
                        r_cy <= -w_ny;
                    end else begin
                        r_cx <= w_nx;
                        r_cy <= w_ny;
                    end
                end
                S_ROT: begin
                    r_prod <= 66'(w_mul);
                    case (r_sub)
                        4'd1: r_acc <= r_prod;
                        4'd2: r_gx <= sat32(rnd(r_acc - r_prod, 30));
                        4'd3: r_acc <= r_prod;
                        4'd4: r_gy <= sat32(rnd(r_acc + r_prod, 30));
                        default: ;
                    endcase
                end
                S_POS: begin
                    r_prod <= 66'(w_mul);
                    case (r_sub)
                        4'd1: r_pos_x <= sat32(66'(r_pos_x) + rnd(r_prod, 16));
                        4'd2: r_pos_y <= sat32(66'(r_pos_y) + rnd(r_prod, 16));
                        default: ;
                    endcase
                end
                S_HEAD: begin
                    case (r_sub)
                        4'd0: r_p <= 48'(w_mul);
                        4'd1: r_m <= r_p[47] ? 48'(-r_p) : r_p;
                        default: r_head <= r_p[47] ? r_head - w_smag[31:0]
                                                   : r_head + w_smag[31:0];
                    endcase
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out.pose_x      <= r_pos_x;
                        r_out.pose_y      <= r_pos_y;
                        r_out.heading     <= r_head;
                        r_out.world_vel_x <= r_gx;
                        r_out.world_vel_y <= r_gy;
                        r_out.turn_rate   <= r_wz;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> hw/rtl/obo_checker.sv
// Checker: port-level properties of the odometry integrator, with bind.
`timescale 1ns / 1ps
module obo_checker
    import obo_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed under stall");

    // Busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted back to back");

    // No result rises in the cycle right after an accept
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result too early");

endmodule

bind omni_base_odometry_integrator_unit obo_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

>>> bench/tb_top.sv
// Testbench for the omni base odometry integrator: directed table, extreme coefficients, then random items.
`timescale 1ns / 1ps
module tb_top;
    import obo_pkg::*;

    localparam int N_RANDOM  = 1100;
    localparam int WDOG_MAX  = 4000;
    localparam int SETTLE    = 60;
    localparam int N_ATAN    = 16;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = REG_COEF_A;
    logic [24:0] i_cfg_data = '0;

    omni_base_odometry_integrator_unit dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state and configuration
    logic [23:0]        coef_a;
    logic [23:0]        coef_b;
    logic signed [24:0] coef_c;
    logic signed [31:0] pose_x_q;
    logic signed [31:0] pose_y_q;
    logic [31:0]        heading_q;

    t_out_item pose_queue[$];
    int  err_count = 0;
    int  wdog = 0;
    bit  done = 0;

    // Directed rows: item plus optional hand-typed expectation
    typedef struct {
        t_in_item  item;
        bit        has_exp;
        t_out_item exp;
    } t_row;
    t_row rows[$];

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Floor shift via arithmetic shift, round by adding half
    function automatic longint round_shr(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    task automatic rotate_sincos(input logic [31:0] ang, output longint co, output longint si);
        logic [31:0] z;
        bit     flip;
        longint x, y, zz, nx;
        z = ang;
        flip = 0;
        if (z >= 32'h40000000 && z < 32'hC0000000) begin
            z = z - 32'h80000000;
            flip = 1;
        end
        zz = longint'($signed(z));
        x = 652032874;
        y = 0;
        for (int i = 0; i < N_ATAN; i++) begin
            if (zz >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                zz = zz - longint'(atan_lut(i[4:0]));
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                zz = zz + longint'(atan_lut(i[4:0]));
            end
            x = nx;
        end
        co = flip ? -x : x;
        si = flip ? -y : y;
    endtask

    // Advance the pose by one item and return the reported result
    task automatic integrate_pose(input t_in_item it, output t_out_item r);
        longint w1, w2, w3, dt, vx, vy, wz, co, si, gx, gy, p;
        longint unsigned m, t, mag;
        logic [31:0] step;
        w1 = it.wheel_speed_1;
        w2 = it.wheel_speed_2;
        w3 = it.wheel_speed_3;
        dt = longint'({1'b0, it.time_step});
        vx = round_shr(longint'({1'b0, coef_a}) * (w2 - w1), 24);
        vy = round_shr(longint'({1'b0, coef_b}) * (2 * w3 - w1 - w2), 24);
        wz = round_shr(longint'(coef_c) * (w1 + w2 + w3), 24);
        rotate_sincos(heading_q, co, si);
        gx = sat32(round_shr(co * vx - si * vy, 30));
        gy = sat32(round_shr(si * vx + co * vy, 30));
        pose_x_q = 32'(sat32(longint'(pose_x_q) + round_shr(gx * dt, 16)));
        pose_y_q = 32'(sat32(longint'(pose_y_q) + round_shr(gy * dt, 16)));
        p = wz * dt;
        m = (p < 0) ? longint'(-p) : p;
        t = m * 10430 + ((m * 27100 + 32768) >> 16);
        mag = (t + 32768) >> 16;
        step = mag[31:0];
        if (p < 0) step = 32'd0 - step;
        heading_q = heading_q + step;
        r.pose_x = pose_x_q;
        r.pose_y = pose_y_q;
        r.heading = heading_q;
        r.world_vel_x = gx[31:0];
        r.world_vel_y = gy[31:0];
        r.turn_rate = 32'(sat32(wz));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Compare each result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pose_queue.size() == 0) begin
                report_mismatch("unexpected item", o_data.pose_x, 32'h0);
            end else begin
                e = pose_queue.pop_front();
                if (o_data.pose_x !== e.pose_x) report_mismatch("pose_x", o_data.pose_x, e.pose_x);
                if (o_data.pose_y !== e.pose_y) report_mismatch("pose_y", o_data.pose_y, e.pose_y);
                if (o_data.heading !== e.heading)
                    report_mismatch("heading", o_data.heading, e.heading);
                if (o_data.world_vel_x !== e.world_vel_x)
                    report_mismatch("world_vel_x", o_data.world_vel_x, e.world_vel_x);
                if (o_data.world_vel_y !== e.world_vel_y)
                    report_mismatch("world_vel_y", o_data.world_vel_y, e.world_vel_y);
                if (o_data.turn_rate !== e.turn_rate)
                    report_mismatch("turn_rate", o_data.turn_rate, e.turn_rate);
            end
        end
    end

    // Stall the output at random, with quiet stretches
    always @(posedge i_clk) begin
        int hold;
        if (hold > 0) begin
            hold--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (o_valid && !i_stall && ($urandom_range(0, 3) != 0))
                hold = $urandom_range(0, 9);
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) wdog <= 0;
        else wdog <= wdog + 1;
        if (!done && wdog >= WDOG_MAX) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [24:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_COEF_A: coef_a = val[23:0];
            REG_COEF_B: coef_b = val[23:0];
            REG_COEF_C: coef_c = val;
            default: ;
        endcase
    endtask

    // Drive one item, predict its result on acceptance; valid stays up when no gap follows
    task automatic send_item(input t_in_item it, input bit has_exp, input t_out_item ex);
        t_out_item r;
        int gap;
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        integrate_pose(it, r);
        if (has_exp && r !== ex) begin
            report_mismatch("table row", r.pose_x, ex.pose_x);
        end
        pose_queue.push_back(has_exp ? ex : r);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_in_item rand_item(int mode);
        t_in_item it;
        it.wheel_speed_1 = 24'($urandom);
        it.wheel_speed_2 = 24'($urandom);
        it.wheel_speed_3 = 24'($urandom);
        it.time_step = 16'($urandom);
        // Mostly moderate speeds so the pose moves without pinning at the limits
        if (mode != 0) begin
            it.wheel_speed_1 = $signed(24'($urandom_range(0, 2 ** 20))) - 24'sd524288;
            it.wheel_speed_2 = $signed(24'($urandom_range(0, 2 ** 20))) - 24'sd524288;
            it.wheel_speed_3 = $signed(24'($urandom_range(0, 2 ** 20))) - 24'sd524288;
            it.time_step = 16'($urandom_range(0, 2000));
        end
        return it;
    endfunction

    t_in_item  it;
    t_out_item zero_res;

    initial begin
        coef_a = COEF_A_RST;
        coef_b = COEF_B_RST;
        coef_c = COEF_C_RST;
        pose_x_q = 0;
        pose_y_q = 0;
        heading_q = 0;
        zero_res = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: zero item after reset has an all-zero result
        rows.push_back('{'{24'sd0, 24'sd0, 24'sd0, 16'd0}, 1, zero_res});
        rows.push_back('{'{24'sd65536, 24'sd65536, 24'sd65536, 16'd0}, 0, zero_res});
        rows.push_back('{'{-24'sd8388608, 24'sd8388607, 24'sd0, 16'hFFFF}, 0, zero_res});
        rows.push_back('{'{24'sd8388607, 24'sd8388607, 24'sd8388607, 16'hFFFF}, 0, zero_res});
        rows.push_back('{'{-24'sd8388608, -24'sd8388608, -24'sd8388608, 16'hFFFF}, 0, zero_res});
        rows.push_back('{'{24'sd0, 24'sd0, 24'sd8388607, 16'hFFFF}, 0, zero_res});
        rows.push_back('{'{24'sd8388607, -24'sd8388608, -24'sd8388608, 16'h8000}, 0, zero_res});
        rows.push_back('{'{24'sd100000, -24'sd3000, 24'sd77, 16'd1}, 0, zero_res});
        foreach (rows[k]) send_item(rows[k].item, rows[k].has_exp, rows[k].exp);
        // Heading wrap: spin hard many times
        repeat (12) send_item('{24'sd8388607, 24'sd8388607, 24'sd8388607, 16'hFFFF}, 0, zero_res);
        drain();

        // Extreme coefficients, then position saturation
        write_reg(REG_COEF_A, 25'hFFFFFF);
        write_reg(REG_COEF_B, 25'hFFFFFF);
        write_reg(REG_COEF_C, 25'h0FFFFFF);
        write_reg(2'd3, 25'h1FFFFFF);
        repeat (6) send_item('{-24'sd8388608, 24'sd8388607, 24'sd8388607, 16'hFFFF}, 0, zero_res);
        repeat (6) send_item('{24'sd8388607, -24'sd8388608, -24'sd8388608, 16'hFFFF}, 0, zero_res);
        drain();
        write_reg(REG_COEF_A, 25'd0);
        write_reg(REG_COEF_B, 25'd0);
        write_reg(REG_COEF_C, 25'h1000000);
        repeat (4) send_item(rand_item(0), 0, zero_res);
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_COEF_A, 25'($urandom));
            write_reg(REG_COEF_B, 25'($urandom));
            write_reg(REG_COEF_C, 25'($urandom));
            if (ph == 3) begin
                write_reg(REG_COEF_A, 25'(COEF_A_RST));
                write_reg(REG_COEF_B, 25'(COEF_B_RST));
                write_reg(REG_COEF_C, COEF_C_RST);
            end
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                it = rand_item($urandom_range(0, 3));
                send_item(it, 0, zero_res);
            end
            drain();
        end

        done = 1;
        if (err_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
